>>> sv/pds_pkg.sv
// Shared types and constants of the point distance sorter.
`default_nettype none

package pds_pkg;

    localparam int COORD_W    = 16;
    localparam int KEY_W      = 35;
    localparam int IDX_W      = 6;
    localparam int REFCNT_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int STEP_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_A_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_A_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_B_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_B_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_C_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_C_Y   = 3'd6;

    typedef struct packed {
        logic [REFCNT_W-1:0] ref_count;
        logic [COORD_W-1:0]  ref_a_x;
        logic [COORD_W-1:0]  ref_a_y;
        logic [COORD_W-1:0]  ref_b_x;
        logic [COORD_W-1:0]  ref_b_y;
        logic [COORD_W-1:0]  ref_c_x;
        logic [COORD_W-1:0]  ref_c_y;
    } t_ref_cfg;

endpackage

`default_nettype wire

>>> sv/pds_key_unit.sv
// Iterative key unit: one shared squarer accumulates the squared distances of a point.
`default_nettype none

module pds_key_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pds_pkg::COORD_W-1:0]  i_point_x,
    input  wire logic [pds_pkg::COORD_W-1:0]  i_point_y,
    input  wire pds_pkg::t_ref_cfg            i_cfg,
    output logic                              o_done,
    output logic [pds_pkg::KEY_W-1:0]         o_key
);
    import pds_pkg::*;

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [COORD_W-1:0]  r_px;
    logic [COORD_W-1:0]  r_py;
    logic [PROD_W-1:0]   r_prod;
    logic [KEY_W-1:0]    r_acc;

    logic [REFCNT_W-1:0] nref;
    logic [STEP_W-1:0]   nsteps;
    logic [COORD_W-1:0]  sel_p;
    logic [COORD_W-1:0]  sel_r;
    logic [COORD_W-1:0]  diff;

    always_comb begin
        nref   = (i_cfg.ref_count == '0) ? REFCNT_W'(1) : i_cfg.ref_count;
        nsteps = {nref, 1'b0};
        unique case (r_step[2:1])
            2'd0:    sel_r = r_step[0] ? i_cfg.ref_a_y : i_cfg.ref_a_x;
            2'd1:    sel_r = r_step[0] ? i_cfg.ref_b_y : i_cfg.ref_b_x;
            default: sel_r = r_step[0] ? i_cfg.ref_c_y : i_cfg.ref_c_x;
        endcase
        sel_p = r_step[0] ? r_py : r_px;
        diff  = (sel_p >= sel_r) ? (sel_p - sel_r) : (sel_r - sel_p);
    end

    assign o_done = r_busy && (r_step == nsteps);
    assign o_key  = r_acc + KEY_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == nsteps) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_acc <= '0;
        end else if (r_busy && (r_step != nsteps)) begin
            r_prod <= PROD_W'(diff) * PROD_W'(diff);
            if (r_step != '0) begin
                r_acc <= o_key;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/point_distance_sorter_top.sv
// Top level of the point distance sorter: config, key store and selection sort.
// Each point's key is built by the shared squarer, one squared span per axis of each active reference.
// After the last point, each rank scans the key store through its single read port.
// Reset is synchronous and active low; it clears control and config, not the key store.
`default_nettype none

module point_distance_sorter_top #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [pds_pkg::COORD_W-1:0]     i_point_x,
    input  wire logic [pds_pkg::COORD_W-1:0]     i_point_y,
    input  wire logic                            i_set_last,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [pds_pkg::IDX_W-1:0]            o_point_index,
    output logic [pds_pkg::KEY_W-1:0]            o_distance_key,
    output logic                                 o_overflow,
    output logic                                 o_rank_last,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pds_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pds_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEY  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state           r_state;
    t_ref_cfg         r_cfg;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic             r_last;

    logic [KEY_W-1:0] r_mem [MAX_POINTS];
    logic [KEY_W-1:0] r_rd_key;
    logic [AW-1:0]    r_addr;
    logic             r_issue;
    logic             r_rd_v;
    logic [AW-1:0]    r_rd_idx;

    logic             r_best_v;
    logic [KEY_W-1:0] r_best_key;
    logic [AW-1:0]    r_best_idx;
    logic             r_have_prev;
    logic [KEY_W-1:0] r_prev_key;
    logic [AW-1:0]    r_prev_idx;
    logic [AW-1:0]    r_rank;

    logic             r_out_valid;
    logic [AW-1:0]    r_out_idx;
    logic [KEY_W-1:0] r_out_key;
    logic             r_out_last;

    logic             in_acc;
    logic             key_done;
    logic [KEY_W-1:0] key_val;
    logic [AW-1:0]    last_addr;
    logic             store_full;
    logic             above_prev;
    logic             cand_ok;
    logic [KEY_W-1:0] pick_key;
    logic [AW-1:0]    pick_idx;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign in_acc         = i_in_valid && !o_in_stall;
    assign store_full     = (r_count == CW'(MAX_POINTS));
    assign last_addr      = AW'(r_count - CW'(1));
    assign o_out_valid    = r_out_valid;
    assign o_point_index  = IDX_W'(r_out_idx);
    assign o_distance_key = r_out_key;
    assign o_overflow     = r_ovf;
    assign o_rank_last    = r_out_last;

    pds_key_unit u_key (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc && !store_full),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_cfg     (r_cfg),
        .o_done    (key_done),
        .o_key     (key_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ref_count: REFCNT_W'(1), default: '0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REF_COUNT: r_cfg.ref_count <= i_cfg_data[REFCNT_W-1:0];
                CFG_REF_A_X:   r_cfg.ref_a_x   <= i_cfg_data;
                CFG_REF_A_Y:   r_cfg.ref_a_y   <= i_cfg_data;
                CFG_REF_B_X:   r_cfg.ref_b_x   <= i_cfg_data;
                CFG_REF_B_Y:   r_cfg.ref_b_y   <= i_cfg_data;
                CFG_REF_C_X:   r_cfg.ref_c_x   <= i_cfg_data;
                CFG_REF_C_Y:   r_cfg.ref_c_y   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_KEY) && key_done) begin
            r_mem[r_count[AW-1:0]] <= key_val;
        end
        r_rd_key <= r_mem[r_addr];
    end

    always_comb begin
        above_prev = !r_have_prev || (r_rd_key > r_prev_key) ||
                     ((r_rd_key == r_prev_key) && (r_rd_idx > r_prev_idx));
        cand_ok    = above_prev && (!r_best_v || (r_rd_key < r_best_key));
        pick_key   = cand_ok ? r_rd_key : r_best_key;
        pick_idx   = cand_ok ? r_rd_idx : r_best_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_issue     <= 1'b0;
            r_rd_v      <= 1'b0;
            r_best_v    <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_rank      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_last <= i_set_last;
                        if (!store_full) begin
                            r_state <= ST_KEY;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_set_last) begin
                                r_state     <= ST_SCAN;
                                r_addr      <= '0;
                                r_issue     <= 1'b1;
                                r_rd_v      <= 1'b0;
                                r_best_v    <= 1'b0;
                                r_have_prev <= 1'b0;
                                r_rank      <= '0;
                            end
                        end
                    end
                end
                ST_KEY: begin
                    if (key_done) begin
                        r_count <= r_count + CW'(1);
                        if (r_last) begin
                            r_state     <= ST_SCAN;
                            r_addr      <= '0;
                            r_issue     <= 1'b1;
                            r_rd_v      <= 1'b0;
                            r_best_v    <= 1'b0;
                            r_have_prev <= 1'b0;
                            r_rank      <= '0;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_issue) begin
                        r_rd_v   <= 1'b1;
                        r_rd_idx <= r_addr;
                        if (r_addr == last_addr) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v) begin
                        if (cand_ok) begin
                            r_best_v   <= 1'b1;
                            r_best_key <= r_rd_key;
                            r_best_idx <= r_rd_idx;
                        end
                        if (r_rd_idx == last_addr) begin
                            r_out_valid <= 1'b1;
                            r_out_key   <= pick_key;
                            r_out_idx   <= pick_idx;
                            r_out_last  <= (r_rank == last_addr);
                            r_state     <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_have_prev <= 1'b1;
                            r_prev_key  <= r_out_key;
                            r_prev_idx  <= r_out_idx;
                            r_rank      <= r_rank + AW'(1);
                            r_addr      <= '0;
                            r_issue     <= 1'b1;
                            r_best_v    <= 1'b0;
                            r_state     <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == ST_EMIT))
        else $error("result beat outside emit state");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_rank_last) |=> ((r_count == '0) && !r_ovf))
        else $error("set state not cleared after final beat");

    a_done_in_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_done |-> (r_state == ST_KEY))
        else $error("key unit finished outside key state");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the point distance sorter: queued point beats, key and rank prediction.
module tb;
    import pds_pkg::*;

    localparam int NPTS     = 64;
    localparam int SETTLE   = 20;
    localparam int LIMIT    = 400000;
    localparam int HOLD_LEN = 800;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } point_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic             ovf;
        logic             last;
    } rank_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [COORD_W-1:0]    i_point_x = '0;
    logic [COORD_W-1:0]    i_point_y = '0;
    logic                  i_set_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [IDX_W-1:0]      o_point_index;
    logic [KEY_W-1:0]      o_distance_key;
    logic                  o_overflow;
    logic                  o_rank_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    point_beat_t point_queue[$];
    rank_t       ranks_due[$];

    t_ref_cfg         ref_cfg;
    logic [KEY_W-1:0] key_store [NPTS];
    int               stored = 0;
    bit               store_ovf = 1'b0;

    int in_launch_cnt = 0;
    int in_acc_cnt = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_req = 0;
    int hold_seen = 0;
    bit idle_on = 1'b1;
    int fail_cnt = 0;
    int cycle_cnt = 0;

    point_distance_sorter_top #(.MAX_POINTS(NPTS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_set_last     (i_set_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_point_index  (o_point_index),
        .o_distance_key (o_distance_key),
        .o_overflow     (o_overflow),
        .o_rank_last    (o_rank_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void queue_point(point_beat_t b);
        point_queue.insert(point_queue.size(), b);
    endfunction

    function automatic logic [KEY_W-1:0] sq_span(logic [COORD_W-1:0] p, logic [COORD_W-1:0] r);
        logic [COORD_W-1:0] d;
        d = (p >= r) ? p - r : r - p;
        return KEY_W'(d) * KEY_W'(d);
    endfunction

    function automatic logic [KEY_W-1:0] dist_key(logic [COORD_W-1:0] px,
                                                  logic [COORD_W-1:0] py);
        logic [KEY_W-1:0] k;
        k = sq_span(px, ref_cfg.ref_a_x) + sq_span(py, ref_cfg.ref_a_y);
        if (ref_cfg.ref_count >= 2)
            k = k + sq_span(px, ref_cfg.ref_b_x) + sq_span(py, ref_cfg.ref_b_y);
        if (ref_cfg.ref_count == 3)
            k = k + sq_span(px, ref_cfg.ref_c_x) + sq_span(py, ref_cfg.ref_c_y);
        return k;
    endfunction

    task automatic rank_stored_points();
        int    order [NPTS];
        int    i;
        int    j;
        rank_t r;
        for (i = 0; i < stored; i++) begin
            j = i;
            while (j > 0 && key_store[order[j-1]] > key_store[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < stored; i++) begin
            r.idx  = IDX_W'(order[i]);
            r.key  = key_store[order[i]];
            r.ovf  = store_ovf;
            r.last = (i == stored - 1);
            ranks_due.insert(ranks_due.size(), r);
        end
        stored = 0;
        store_ovf = 1'b0;
    endtask

    always @(posedge i_clk) begin
        rank_t want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_acc_cnt <= in_acc_cnt + 1;
                if (stored < NPTS) begin
                    key_store[stored] = dist_key(i_point_x, i_point_y);
                    stored++;
                end else begin
                    store_ovf = 1'b1;
                end
                if (i_set_last)
                    rank_stored_points();
            end
            if (o_out_valid && !i_out_stall) begin
                if (ranks_due.size() == 0) begin
                    $error("unexpected result beat: point_index %0d, distance_key %0d",
                           o_point_index, o_distance_key);
                    fail_cnt++;
                end else begin
                    want = ranks_due.pop_front();
                    if (o_point_index !== want.idx) begin
                        $error("point_index: expected %0d, actual %0d", want.idx, o_point_index);
                        fail_cnt++;
                    end
                    if (o_distance_key !== want.key) begin
                        $error("distance_key: expected %0d, actual %0d", want.key, o_distance_key);
                        fail_cnt++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %0d, actual %0d", want.ovf, o_overflow);
                        fail_cnt++;
                    end
                    if (o_rank_last !== want.last) begin
                        $error("rank_last: expected %0d, actual %0d", want.last, o_rank_last);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        point_beat_t b;
        if (i_rst_n && (!i_in_valid || in_acc_cnt == in_launch_cnt)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (point_queue.size() != 0) begin
                b = point_queue.pop_front();
                i_point_x     <= b.x;
                i_point_y     <= b.y;
                i_set_last    <= b.last;
                i_in_valid    <= 1'b1;
                in_launch_cnt <= in_launch_cnt + 1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (point_queue.size() != 0 || in_acc_cnt != in_launch_cnt || ranks_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_REF_COUNT: ref_cfg.ref_count = data[REFCNT_W-1:0];
            CFG_REF_A_X:   ref_cfg.ref_a_x = data;
            CFG_REF_A_Y:   ref_cfg.ref_a_y = data;
            CFG_REF_B_X:   ref_cfg.ref_b_x = data;
            CFG_REF_B_Y:   ref_cfg.ref_b_y = data;
            CFG_REF_C_X:   ref_cfg.ref_c_x = data;
            CFG_REF_C_Y:   ref_cfg.ref_c_y = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic rand_cfg();
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] v;
        cfg_write(CFG_REF_COUNT, CFG_DATA_W'($urandom));
        for (reg_sel = CFG_REF_A_X; reg_sel <= CFG_REF_C_Y; reg_sel++) begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1:       v = '1;
                default: v = CFG_DATA_W'($urandom);
            endcase
            cfg_write(reg_sel, v);
        end
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    function automatic point_beat_t rand_point(logic last);
        point_beat_t b;
        case ($urandom_range(0, 3))
            0: begin
                b.x = COORD_W'($urandom);
                b.y = COORD_W'($urandom);
            end
            1: begin
                b.x = ref_cfg.ref_a_x + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
                b.y = ref_cfg.ref_a_y + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
            end
            2: begin
                b.x = COORD_W'(16'h0100 + $urandom_range(0, 2));
                b.y = COORD_W'(16'h0100 + $urandom_range(0, 2));
            end
            default: begin
                b.x = $urandom_range(0, 1) ? '1 : '0;
                b.y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
        endcase
        b.last = last;
        return b;
    endfunction

    task automatic send_set(int n, int split);
        int p;
        for (p = 0; p < n; p++) begin
            if (p == split) begin
                wait_idle();
                cfg_write(CFG_REF_A_X + CFG_IDX_W'($urandom_range(0, 5)), CFG_DATA_W'($urandom));
            end
            queue_point(rand_point(p == n - 1));
        end
    endtask

    initial begin
        int phase;
        int sent;
        int s;
        int n;
        ref_cfg = '0;
        ref_cfg.ref_count = REFCNT_W'(1);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_point('{16'h0000, 16'h0000, 1'b0});
        queue_point('{16'hFFFF, 16'hFFFF, 1'b0});
        queue_point('{16'hFFFF, 16'h0000, 1'b0});
        queue_point('{16'h0000, 16'hFFFF, 1'b1});
        wait_idle();
        queue_point('{16'h1234, 16'h5678, 1'b1});
        wait_idle();

        cfg_write(CFG_REF_COUNT, 16'h0003);
        cfg_write(CFG_REF_A_X, 16'hFFFF);
        cfg_write(CFG_REF_A_Y, 16'hFFFF);
        cfg_write(CFG_REF_B_X, 16'hFFFF);
        cfg_write(CFG_REF_B_Y, 16'hFFFF);
        cfg_write(CFG_REF_C_X, 16'hFFFF);
        cfg_write(CFG_REF_C_Y, 16'hFFFF);
        queue_point('{16'h0000, 16'h0000, 1'b0});
        queue_point('{16'hFFFF, 16'hFFFF, 1'b1});
        wait_idle();

        cfg_write(CFG_REF_COUNT, 16'hFFFC);
        cfg_write(CFG_REF_A_X, 16'h0008);
        cfg_write(CFG_REF_A_Y, 16'h0008);
        queue_point('{16'h000A, 16'h000A, 1'b0});
        queue_point('{16'h000A, 16'h000A, 1'b0});
        queue_point('{16'h0005, 16'h0005, 1'b0});
        queue_point('{16'h0006, 16'h000A, 1'b1});
        wait_idle();

        cfg_write(CFG_REF_COUNT, 16'h0002);
        cfg_write(CFG_REF_B_X, 16'h8000);
        cfg_write(CFG_REF_B_Y, 16'h7FFF);
        cfg_write(CFG_UNUSED, 16'hFFFF);
        queue_point('{16'h0064, 16'h00C8, 1'b0});
        queue_point('{16'h012C, 16'h0190, 1'b0});
        wait_idle();
        cfg_write(CFG_REF_A_X, 16'h4000);
        queue_point('{16'h01F4, 16'h0258, 1'b0});
        queue_point('{16'h02BC, 16'h0320, 1'b1});

        phase = 0;
        sent = 0;
        while (sent < 190) begin
            wait_idle();
            rand_cfg();
            idle_on = (phase % 4 != 2);
            if (phase == 1)
                hold_req++;
            for (s = $urandom_range(2, 5); s > 0; s--) begin
                if (phase == 3 && s == 1)
                    n = NPTS + 2;
                else if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(9, 16);
                else
                    n = $urandom_range(1, 8);
                if (n > 2 && $urandom_range(0, 5) == 0)
                    send_set(n, $urandom_range(1, n - 1));
                else
                    send_set(n, -1);
                sent += n;
            end
            phase++;
        end

        wait_idle();
        idle_on = 1'b0;
        rand_cfg();
        for (s = 0; s < 4; s++)
            send_set($urandom_range(1, 8), -1);
        wait_idle();

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
